// ===== sv/obt_pkg.sv =====
// ----------------------------------------------------------------------------
// obt_pkg: shared types and constants of the orthonormal basis transform
// Fixed point formats, register indexes and the basis bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package obt_pkg;

  localparam int unsigned AxisW  = 16;  // axis register width
  localparam int unsigned PointW = 16;  // Q8.8 input coordinate
  localparam int unsigned WorldW = 17;  // Q9.8 output coordinate
  localparam int unsigned UnitW  = 16;  // Q1.14 unit component, +/-1.0 inclusive
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [AxisW-1:0] AxisXReset = 16'sd0;
  localparam logic signed [AxisW-1:0] AxisYReset = 16'sd0;
  localparam logic signed [AxisW-1:0] AxisZReset = 16'sd32767;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAxisX = 2'd0,
    CfgAxisY = 2'd1,
    CfgAxisZ = 2'd2
  } cfg_idx_e;

  // Basis in Q1.14, element 0 is the x component
  typedef struct packed {
    logic                        degenerate;
    logic [2:0][UnitW-1:0]       x;
    logic [2:0][UnitW-1:0]       y;
    logic [2:0][UnitW-1:0]       z;
  } basis_t;

endpackage

`default_nettype wire

// ===== sv/obt_if.sv =====
// ----------------------------------------------------------------------------
// obt_if: point and result channel interfaces
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface obt_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [obt_pkg::PointW-1:0]      point_x;
  logic signed [obt_pkg::PointW-1:0]      point_y;
  logic signed [obt_pkg::PointW-1:0]      point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface obt_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [obt_pkg::WorldW-1:0]      world_x;
  logic signed [obt_pkg::WorldW-1:0]      world_y;
  logic signed [obt_pkg::WorldW-1:0]      world_z;
  logic                                   degenerate;

  modport source (output valid, output world_x, output world_y, output world_z,
                  output degenerate, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z,
                  input degenerate, output ready);
endinterface

`default_nettype wire

// ===== sv/obt_basis.sv =====
// ----------------------------------------------------------------------------
// obt_basis: basis sequencer
// Holds the axis registers and, after reset or a register write, rebuilds
// the Q1.14 basis with one shared 32x32 multiplier and a 16x16 signed one.
// ----------------------------------------------------------------------------
`default_nettype none

module obt_basis (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [obt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [obt_pkg::AxisW-1:0]       cfg_data_i,
  output logic                            busy_o,
  output obt_pkg::basis_t                 basis_o
);

  typedef enum logic [13:0] {
    StIdle   = 14'b00000000000001,
    StLoad   = 14'b00000000000010,
    StSqMul  = 14'b00000000000100,
    StSqAcc  = 14'b00000000001000,
    StSqChk  = 14'b00000000010000,
    StMagMul = 14'b00000000100000,
    StMagSav = 14'b00000001000000,
    StDMul   = 14'b00000010000000,
    StDsMul  = 14'b00000100000000,
    StCmp    = 14'b00001000000000,
    StPerp   = 14'b00010000000000,
    StXa     = 14'b00100000000000,
    StXb     = 14'b01000000000000,
    StXc     = 14'b10000000000000
  } state_e;

  function automatic logic [15:0] mag17(logic signed [16:0] v);
    logic signed [16:0] n;
    n = (v < 0) ? -v : v;
    return n[15:0];
  endfunction

  function automatic logic [15:0] abs16(logic signed [15:0] v);
    return (v < 0) ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [1:0] rot1(logic [1:0] j);
    case (j)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] rot2(logic [1:0] j);
    case (j)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  state_e state_q;
  logic signed [obt_pkg::AxisW-1:0] axis_q [3];
  logic signed [16:0]  vec_q [3];
  logic signed [15:0]  z_q [3];
  logic signed [15:0]  y_q [3];
  logic signed [15:0]  x_q [3];
  logic                deg_q;
  logic                phase_y_q;   // 0: axis -> Z, 1: perpendicular -> Y
  logic [1:0]          idx_q;
  logic [3:0]          bit_q;
  logic [14:0]         m_q;
  logic [31:0]         ss_q;
  logic [60:0]         rhs_q;
  logic [63:0]         prod_d, prod_q;
  logic [31:0]         mul_a, mul_b;
  logic signed [15:0]  xm_a, xm_b;
  logic signed [31:0]  xprod_d, xprod_q, xp1_q;

  logic [14:0]         t_w;
  logic [15:0]         d_w;
  logic                take_w;
  logic [14:0]         m_new;
  logic [15:0]         u_abs;
  logic [15:0]         u_val;
  logic signed [32:0]  diff_w;
  logic signed [32:0]  rs_w;
  logic signed [15:0]  xt_w;
  logic [1:0]          j1, j2;

  assign t_w    = m_q | (15'd1 << bit_q);
  assign d_w    = {t_w, 1'b0} - 16'd1;
  assign take_w = (t_w <= 15'd16384) && (prod_q <= {3'b000, rhs_q});
  assign m_new  = take_w ? t_w : m_q;
  assign u_abs  = {1'b0, m_new};
  assign u_val  = (vec_q[idx_q] < 0) ? 16'(-u_abs) : u_abs;

  assign j1 = rot1(idx_q);
  assign j2 = rot2(idx_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSqMul, StMagMul: begin
        mul_a = {16'd0, mag17(vec_q[idx_q])};
        mul_b = {16'd0, mag17(vec_q[idx_q])};
      end
      StDMul: begin
        mul_a = {16'd0, d_w};
        mul_b = {16'd0, d_w};
      end
      StDsMul: begin
        mul_a = {2'b00, prod_q[29:0]};
        mul_b = ss_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    if (state_q == StXb) begin
      xm_a = y_q[j2];
      xm_b = z_q[j1];
    end else begin
      xm_a = y_q[j1];
      xm_b = z_q[j2];
    end
  end

  assign xprod_d = xm_a * xm_b;

  // round half up to Q1.14 and clamp to +/-1.0
  assign diff_w = 33'(xp1_q) - 33'(xprod_q);
  assign rs_w   = (diff_w + 33'sd8192) >>> 14;
  always_comb begin
    if (rs_w > 33'sd16384) begin
      xt_w = 16'sd16384;
    end else if (rs_w < -33'sd16384) begin
      xt_w = -16'sd16384;
    end else begin
      xt_w = rs_w[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    xprod_q <= xprod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      axis_q[0] <= obt_pkg::AxisXReset;
      axis_q[1] <= obt_pkg::AxisYReset;
      axis_q[2] <= obt_pkg::AxisZReset;
      deg_q     <= 1'b0;
      phase_y_q <= 1'b0;
      idx_q     <= '0;
      bit_q     <= '0;
      m_q       <= '0;
      ss_q      <= '0;
    end else if (cfg_we_i && (cfg_idx_i == obt_pkg::CfgAxisX ||
                              cfg_idx_i == obt_pkg::CfgAxisY ||
                              cfg_idx_i == obt_pkg::CfgAxisZ)) begin
      axis_q[cfg_idx_i] <= cfg_data_i;
      state_q           <= StLoad;
    end else begin
      case (state_q)
        StLoad: begin
          for (int i = 0; i < 3; i++) begin
            vec_q[i] <= 17'(axis_q[i]);
          end
          deg_q     <= 1'b0;
          phase_y_q <= 1'b0;
          idx_q     <= '0;
          ss_q      <= '0;
          state_q   <= StSqMul;
        end
        StSqMul: state_q <= StSqAcc;
        StSqAcc: begin
          ss_q <= ss_q + prod_q[31:0];
          if (idx_q == 2'd2) begin
            state_q <= StSqChk;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= StSqMul;
          end
        end
        StSqChk: begin
          idx_q <= '0;
          if (ss_q != '0) begin
            state_q <= StMagMul;
          end else if (!phase_y_q) begin
            // zero axis: all-zero basis gives a zero result
            deg_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              z_q[i] <= '0;
              y_q[i] <= '0;
              x_q[i] <= '0;
            end
            state_q <= StIdle;
          end else begin
            for (int i = 0; i < 3; i++) begin
              y_q[i] <= '0;
            end
            state_q <= StXa;
          end
        end
        StMagMul: state_q <= StMagSav;
        StMagSav: begin
          rhs_q   <= {prod_q[30:0], 30'd0};
          bit_q   <= 4'd14;
          m_q     <= '0;
          state_q <= StDMul;
        end
        StDMul:  state_q <= StDsMul;
        StDsMul: state_q <= StCmp;
        StCmp: begin
          m_q <= m_new;
          if (bit_q == '0) begin
            if (phase_y_q) begin
              y_q[idx_q] <= u_val;
            end else begin
              z_q[idx_q] <= u_val;
            end
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              state_q <= phase_y_q ? StXa : StPerp;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= StMagMul;
            end
          end else begin
            bit_q   <= bit_q - 4'd1;
            state_q <= StDMul;
          end
        end
        StPerp: begin
          if (abs16(z_q[0]) > abs16(z_q[2])) begin
            vec_q[0] <= -{z_q[1][15], z_q[1]};
            vec_q[1] <= {z_q[0][15], z_q[0]};
            vec_q[2] <= '0;
          end else begin
            vec_q[0] <= '0;
            vec_q[1] <= -{z_q[2][15], z_q[2]};
            vec_q[2] <= {z_q[1][15], z_q[1]};
          end
          phase_y_q <= 1'b1;
          idx_q     <= '0;
          ss_q      <= '0;
          state_q   <= StSqMul;
        end
        StXa: state_q <= StXb;
        StXb: begin
          xp1_q   <= xprod_q;
          state_q <= StXc;
        end
        StXc: begin
          x_q[idx_q] <= xt_w;
          if (idx_q == 2'd2) begin
            state_q <= StIdle;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= StXa;
          end
        end
        StIdle: ;
        default: state_q <= StLoad;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    basis_o.degenerate = deg_q;
    for (int i = 0; i < 3; i++) begin
      basis_o.x[i] = x_q[i];
      basis_o.y[i] = y_q[i];
      basis_o.z[i] = z_q[i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/obt_datapath.sv =====
// ----------------------------------------------------------------------------
// obt_datapath: point transform pipeline
// Products, sums, then round and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module obt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              busy_i,
  input  obt_pkg::basis_t   basis_i,
  obt_in_if.sink            in_i,
  obt_out_if.source         out_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic in_fire;

  logic signed [30:0] p_q [3][3];   // [output axis][point component]
  logic               deg1_q, deg2_q;
  logic signed [31:0] s_q [3];
  logic signed [obt_pkg::WorldW-1:0] w_d [3];
  logic signed [obt_pkg::WorldW-1:0] w_q [3];
  logic               deg3_q;
  logic signed [15:0] pt [3];

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1 && !busy_i;
  assign in_fire    = in_i.valid && in_i.ready;

  assign pt[0] = in_i.point_x;
  assign pt[1] = in_i.point_y;
  assign pt[2] = in_i.point_z;

  // round half up to Q9.8, saturate to 17 bits
  always_comb begin
    logic signed [32:0] r;
    for (int i = 0; i < 3; i++) begin
      r = (33'(s_q[i]) + 33'sd8192) >>> 14;
      if (r > 33'sd65535) begin
        w_d[i] = 17'sd65535;
      end else if (r < -33'sd65536) begin
        w_d[i] = -17'sd65536;
      end else begin
        w_d[i] = r[16:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_fire;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_fire) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i][0] <= 31'(pt[0] * $signed(basis_i.x[i]));
        p_q[i][1] <= 31'(pt[1] * $signed(basis_i.y[i]));
        p_q[i][2] <= 31'(pt[2] * $signed(basis_i.z[i]));
      end
      deg1_q <= basis_i.degenerate;
    end
    if (en2 && v1_q) begin
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= 32'(p_q[i][0]) + 32'(p_q[i][1]) + 32'(p_q[i][2]);
      end
      deg2_q <= deg1_q;
    end
    if (en3 && v2_q) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= w_d[i];
      end
      deg3_q <= deg2_q;
    end
  end

  assign out_o.valid      = v3_q;
  assign out_o.world_x    = w_q[0];
  assign out_o.world_y    = w_q[1];
  assign out_o.world_z    = w_q[2];
  assign out_o.degenerate = deg3_q;

endmodule

`default_nettype wire

// ===== sv/orthonormal_basis_transform_core.sv =====
// ----------------------------------------------------------------------------
// orthonormal_basis_transform_core: maps Q8.8 basis coordinates to world
// Basis built from the axis registers; points stream through a 3-stage pipe.
// ----------------------------------------------------------------------------
// One point per cycle unless the basis is busy or the output stalls; points
// pass the product, sum and output registers. After reset or any axis write
// bitwise normalization on the shared multiplier rebuilds the basis; input
// ready stays low meanwhile. Reset: async active low, axis = (0, 0, 32767).
`default_nettype none

module orthonormal_basis_transform_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [obt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [obt_pkg::AxisW-1:0]       cfg_data_i,
  obt_in_if.sink                          in_i,
  obt_out_if.source                       out_o
);

  logic            busy;
  obt_pkg::basis_t basis;

  obt_basis u_basis (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .basis_o    (basis)
  );

  obt_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_i  (busy),
    .basis_i (basis),
    .in_i    (in_i),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== sim/obt_checker.sv =====
// ----------------------------------------------------------------------------
// obt_checker: result predictor and scoreboard for the basis transform
// Tracks axis register writes, predicts each world point from every input
// transfer and compares it field by field with the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module obt_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [obt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [obt_pkg::AxisW-1:0]   cfg_data_i,
  obt_in_if                           in_ch,
  obt_out_if                          out_ch,
  output int                          fail_count,
  output int                          pending_count,
  output int                          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint OneQ14   = 16384;
  localparam longint WorldMax = 65535;
  localparam longint WorldMin = -65536;

  typedef struct {
    logic signed [obt_pkg::WorldW-1:0] wx;
    logic signed [obt_pkg::WorldW-1:0] wy;
    logic signed [obt_pkg::WorldW-1:0] wz;
    logic                              degenerate;
  } world_pt_t;

  logic signed [obt_pkg::AxisW-1:0] axis_x, axis_y, axis_z;
  world_pt_t                        world_q[$];

  // exact round-half-up of |a| * 2^14 / sqrt(ss), sign of a
  function automatic longint unit_q14(longint a, longint unsigned ss);
    longint unsigned mag, rhs, m, t, d;
    mag = (a < 0) ? -a : a;
    rhs = 4 * mag * mag * (64'd1 << 28);
    m = 0;
    for (int b = 14; b >= 0; b--) begin
      t = m | (64'd1 << b);
      d = 2 * t - 1;
      if (t <= OneQ14 && d * d * ss <= rhs) m = t;
    end
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic bit unitize(input longint v[3], output longint u[3]);
    longint unsigned ss;
    ss = 0;
    for (int i = 0; i < 3; i++) ss += v[i] * v[i];
    for (int i = 0; i < 3; i++) u[i] = (ss == 0) ? 0 : unit_q14(v[i], ss);
    return ss != 0;
  endfunction

  function automatic longint round_q14(longint v);
    return (v + (64'sd1 << 13)) >>> 14;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint cross_q14(longint a, longint b, longint c, longint d);
    return clip(round_q14(a * b - c * d), -OneQ14, OneQ14);
  endfunction

  function automatic world_pt_t to_world(logic signed [obt_pkg::PointW-1:0] px,
                                         logic signed [obt_pkg::PointW-1:0] py,
                                         logic signed [obt_pkg::PointW-1:0] pz);
    longint    av[3], zu[3], perp[3], yu[3], xu[3];
    longint    s, r;
    world_pt_t w;
    av[0] = axis_x;
    av[1] = axis_y;
    av[2] = axis_z;
    w.degenerate = 1'b0;
    if (!unitize(av, zu)) begin
      w.wx = '0;
      w.wy = '0;
      w.wz = '0;
      w.degenerate = 1'b1;
      return w;
    end
    // perpendicular: (-zy, zx, 0) when |zx| exceeds |zz|, else (0, -zz, zy)
    if ((zu[0] < 0 ? -zu[0] : zu[0]) > (zu[2] < 0 ? -zu[2] : zu[2])) begin
      perp[0] = -zu[1];
      perp[1] = zu[0];
      perp[2] = 0;
    end else begin
      perp[0] = 0;
      perp[1] = -zu[2];
      perp[2] = zu[1];
    end
    void'(unitize(perp, yu));
    xu[0] = cross_q14(yu[1], zu[2], yu[2], zu[1]);
    xu[1] = cross_q14(yu[2], zu[0], yu[0], zu[2]);
    xu[2] = cross_q14(yu[0], zu[1], yu[1], zu[0]);
    for (int i = 0; i < 3; i++) begin
      s = longint'(px) * xu[i] + longint'(py) * yu[i] + longint'(pz) * zu[i];
      r = clip(round_q14(s), WorldMin, WorldMax);
      if (i == 0) w.wx = r[obt_pkg::WorldW-1:0];
      else if (i == 1) w.wy = r[obt_pkg::WorldW-1:0];
      else w.wz = r[obt_pkg::WorldW-1:0];
    end
    return w;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    world_pt_t want;
    if (!rst_ni) begin
      axis_x = obt_pkg::AxisXReset;
      axis_y = obt_pkg::AxisYReset;
      axis_z = obt_pkg::AxisZReset;
      world_q.delete();
      fail_count = 0;
      checked_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (world_q.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          want = world_q.pop_front();
          checked_count++;
          if (out_ch.world_x !== want.wx) report_mismatch("world_x", out_ch.world_x, want.wx);
          if (out_ch.world_y !== want.wy) report_mismatch("world_y", out_ch.world_y, want.wy);
          if (out_ch.world_z !== want.wz) report_mismatch("world_z", out_ch.world_z, want.wz);
          if (out_ch.degenerate !== want.degenerate)
            report_mismatch("degenerate", out_ch.degenerate, want.degenerate);
        end
      end
      if (in_ch.valid && in_ch.ready)
        world_q.push_back(to_world(in_ch.point_x, in_ch.point_y, in_ch.point_z));
      if (cfg_we_i) begin
        case (obt_pkg::cfg_idx_e'(cfg_idx_i))
          obt_pkg::CfgAxisX: axis_x = cfg_data_i;
          obt_pkg::CfgAxisY: axis_y = cfg_data_i;
          obt_pkg::CfgAxisZ: axis_z = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_count <= world_q.size();
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the orthonormal basis transform core
// Sweeps a set of axis settings, from degenerate and extreme axes to random
// ones, and streams points through each with random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PointsPerAxis = 110;
  localparam int CycleLimit    = 400000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [obt_pkg::CfgIdxW-1:0]  cfg_idx_i = obt_pkg::CfgAxisX;
  logic [obt_pkg::AxisW-1:0]    cfg_data_i = '0;
  int                           fail_count, pending_count, checked_count;
  int                           cycles = 0;
  int                           points_sent = 0;
  int                           axis_settings = 0;
  bit                           send_calm = 1'b0;

  obt_in_if  in_if ();
  obt_out_if out_if ();

  orthonormal_basis_transform_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i (in_if.sink), .out_o (out_if.source)
  );

  obt_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch (in_if), .out_ch (out_if),
    .fail_count, .pending_count, .checked_count
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
  end

  // result side: random stalls with calm stretches
  initial begin
    int  stall;
    bit  calm;
    out_if.ready = 1'b0;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  task automatic send_point(logic [obt_pkg::PointW-1:0] px, logic [obt_pkg::PointW-1:0] py,
                            logic [obt_pkg::PointW-1:0] pz);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.point_x <= px;
    in_if.point_y <= py;
    in_if.point_z <= pz;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    points_sent++;
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_axis(logic [obt_pkg::AxisW-1:0] ax, logic [obt_pkg::AxisW-1:0] ay,
                            logic [obt_pkg::AxisW-1:0] az);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= obt_pkg::CfgAxisX;
    cfg_data_i <= ax;
    @(negedge clk_i);
    cfg_idx_i <= obt_pkg::CfgAxisY;
    cfg_data_i <= ay;
    @(negedge clk_i);
    cfg_idx_i <= obt_pkg::CfgAxisZ;
    cfg_data_i <= az;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    axis_settings++;
  endtask

  function automatic logic [obt_pkg::PointW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return obt_pkg::PointW'($urandom_range(0, 511) - 256);
      1: return obt_pkg::PointW'($urandom_range(0, 8191) - 4096);
      default: return obt_pkg::PointW'($urandom);
    endcase
  endfunction

  // extreme points, then random ones, under the current axis
  task automatic point_burst(int count);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0100, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'h0100, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h0100);
    send_point(16'h8000, 16'h7fff, 16'hffff);
    send_point(16'h0001, 16'hffff, 16'h0001);
    for (int i = 8; i < count; i++) begin
      if ($urandom_range(0, 31) == 0) send_calm = ~send_calm;
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  function automatic logic [obt_pkg::AxisW-1:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return obt_pkg::AxisW'($urandom_range(0, 6) - 3);
      1: return obt_pkg::AxisW'($urandom_range(0, 400) - 200);
      default: return obt_pkg::AxisW'($urandom);
    endcase
  endfunction

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    axis_settings = 1;
    point_burst(PointsPerAxis);       // reset axis
    write_axis(16'h0000, 16'h0000, 16'h0000);  // zero axis flags degenerate
    point_burst(20);
    write_axis(16'h8000, 16'h8000, 16'h8000);
    point_burst(PointsPerAxis);
    write_axis(16'h7fff, 16'h7fff, 16'h7fff);
    point_burst(PointsPerAxis);
    write_axis(16'h7fff, 16'h8000, 16'h0000);
    point_burst(PointsPerAxis);
    write_axis(16'h0001, 16'h0000, 16'h0000);
    point_burst(PointsPerAxis);
    write_axis(16'h0000, 16'hffff, 16'h0000);
    point_burst(PointsPerAxis);
    write_axis(16'h0000, 16'h0000, 16'h8000);
    point_burst(PointsPerAxis);
    write_axis(16'd100, 16'd5, -16'sd100);  // |zx| equal to |zz|
    point_burst(PointsPerAxis);
    write_axis(16'd200, 16'd3, -16'sd100);  // |zx| above |zz|
    point_burst(PointsPerAxis);
    for (int k = 0; k < 6; k++) begin
      write_axis(rand_axis(), rand_axis(), rand_axis());
      point_burst(PointsPerAxis);
    end
    drain();
    repeat (20) @(negedge clk_i);
    $display("sent %0d points under %0d axis settings, %0d results checked",
             points_sent, axis_settings, checked_count);
    $display("axes covered: reset, zero, full-scale corners, unit axes, random");
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
